@@ hw/rtl/vvtcp_pkg.sv @@
package vvtcp_pkg;

  // fixed widths of the coordinate formats
  localparam int unsigned CoordW    = 32;
  localparam int unsigned RowW      = 48;
  localparam int unsigned EntryW    = 16;
  localparam int unsigned CanvasW   = 13;
  localparam int unsigned CodesW    = 5;
  localparam int unsigned RecipW    = 17;
  localparam int unsigned CfgIdxW   = 3;

  // divider geometry: numerator magnitude |x| * W * 2^16 < 2^60, divisor z < 2^31
  localparam int unsigned DivNumW   = 60;
  localparam int unsigned DivDenW   = 31;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_VIEW_POS_X    = 3'd0,
    REG_VIEW_POS_Y    = 3'd1,
    REG_VIEW_POS_Z    = 3'd2,
    REG_RIGHT_ROW     = 3'd3,
    REG_UP_ROW        = 3'd4,
    REG_FORWARD_ROW   = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } cfg_reg_t;

  // one view-space point
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } view_t;

  // side data that rides along the divider pipeline
  typedef struct packed {
    view_t             view;
    logic [CodesW-1:0] codes;
    logic              pos;
    logic              neg_x;
    logic              neg_y;
  } side_t;

  // signed q2.14 entry k of a packed matrix row
  function automatic logic signed [EntryW-1:0] row_entry(input logic [RowW-1:0] row,
                                                         input int unsigned k);
    row_entry = signed'(row[EntryW*k +: EntryW]);
  endfunction

endpackage

@@ hw/rtl/vertex_view_transform_clip_project_core.sv @@
// Vertex view transform, clip codes and perspective projection. One vertex
// word is accepted every cycle while the output side takes results. A word
// passes the translate, rotate and saturate registers, the divider operand
// register, the one-bit-per-stage quotient pipelines (their depth set by
// the 60-bit numerator of x * width * 2^16 / z) and the output register.
// The whole pipeline holds while a finished word waits at the output.
// Configuration registers are to be written only while the pipeline is
// empty; the block does not enforce this. cfg_ready is always high.
module vertex_view_transform_clip_project_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vvtcp_pkg::CoordW-1:0]  in_world_x,
  input  logic [vvtcp_pkg::CoordW-1:0]  in_world_y,
  input  logic [vvtcp_pkg::CoordW-1:0]  in_world_z,
  input  logic                          in_skip_translate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vvtcp_pkg::CoordW-1:0]  out_view_x,
  output logic [vvtcp_pkg::CoordW-1:0]  out_view_y,
  output logic [vvtcp_pkg::CoordW-1:0]  out_view_z,
  output logic [vvtcp_pkg::CodesW-1:0]  out_clip_codes,
  output logic                          out_projected,
  output logic [vvtcp_pkg::CoordW-1:0]  out_screen_x,
  output logic [vvtcp_pkg::CoordW-1:0]  out_screen_y,
  output logic [vvtcp_pkg::RecipW-1:0]  out_recip_depth,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vvtcp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vvtcp_pkg::RowW-1:0]    cfg_data
);
  import vvtcp_pkg::*;

  localparam int unsigned SideW = $bits(side_t);
  localparam int unsigned QW    = DivNumW + 1;
  localparam int unsigned SumW  = QW + 1;
  localparam int unsigned MulW  = CoordW + CanvasW;
  localparam logic [DivNumW-1:0] RecipNum = DivNumW'(64'h1_0000_0000);
  localparam logic [RecipW-1:0]  OneQ16   = RecipW'(65536);

  logic [CoordW-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [RowW-1:0]    right_r, up_r, fwd_r;
  logic [CanvasW-1:0] width_r, height_r;

  logic               en;
  logic               view_valid;
  view_t              view;

  logic               vd_r;
  side_t              side_d_r;
  logic [DivNumW-1:0] numx_d_r, numy_d_r;
  logic [DivDenW-1:0] den_d_r;
  side_t              side_nxt;
  logic [CoordW-1:0]  absx, absy;
  logic [MulW-1:0]    mulx, muly;
  logic signed [CoordW:0] x33, y33, z33;

  logic               ve;
  side_t              side_e;
  logic [DivNumW-1:0] qx, qy, qr;

  logic               out_valid_r;
  logic [CoordW-1:0]  vx_r, vy_r, vz_r, sx_r, sy_r;
  logic [CodesW-1:0]  codes_r;
  logic               proj_r;
  logic [RecipW-1:0]  rd_r;
  logic [CoordW-1:0]  sx_nxt, sy_nxt;
  logic [RecipW-1:0]  rd_nxt;
  logic signed [QW-1:0]   sqx, sqy;
  logic signed [SumW-1:0] sumx, sumy;

  function automatic logic [CoordW-1:0] sat_q(input logic [QW-1:0] v);
    if (v[QW-1:CoordW-1] == '0 || v[QW-1:CoordW-1] == '1) begin
      sat_q = v[CoordW-1:0];
    end else if (v[QW-1]) begin
      sat_q = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  // pipeline advances when the output word is empty or taken
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      right_r  <= RowW'(48'h0000_0000_4000);
      up_r     <= RowW'(48'h0000_4000_0000);
      fwd_r    <= RowW'(48'h4000_0000_0000);
      width_r  <= CanvasW'(640);
      height_r <= CanvasW'(480);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_POS_X:    pos_x_r  <= cfg_data[CoordW-1:0];
        REG_VIEW_POS_Y:    pos_y_r  <= cfg_data[CoordW-1:0];
        REG_VIEW_POS_Z:    pos_z_r  <= cfg_data[CoordW-1:0];
        REG_RIGHT_ROW:     right_r  <= cfg_data;
        REG_UP_ROW:        up_r     <= cfg_data;
        REG_FORWARD_ROW:   fwd_r    <= cfg_data;
        REG_CANVAS_WIDTH:  width_r  <= cfg_data[CanvasW-1:0];
        REG_CANVAS_HEIGHT: height_r <= cfg_data[CanvasW-1:0];
        default: ;
      endcase
    end
  end

  // translate and rotate
  vvtcp_rotate u_rotate (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .world_x        (in_world_x),
    .world_y        (in_world_y),
    .world_z        (in_world_z),
    .skip_translate (in_skip_translate),
    .pos_x          (pos_x_r),
    .pos_y          (pos_y_r),
    .pos_z          (pos_z_r),
    .row_r0         (right_r),
    .row_u0         (up_r),
    .row_f0         (fwd_r),
    .view_valid     (view_valid),
    .view           (view)
  );

  // clip codes and divider operands
  always_comb begin
    x33  = signed'({view.x[CoordW-1], view.x});
    y33  = signed'({view.y[CoordW-1], view.y});
    z33  = signed'({view.z[CoordW-1], view.z});
    absx = view.x[CoordW-1] ? (~view.x + 1'b1) : view.x;
    absy = view.y[CoordW-1] ? (~view.y + 1'b1) : view.y;
    mulx = MulW'(absx) * MulW'(width_r);
    muly = MulW'(absy) * MulW'(height_r);
    side_nxt.view     = view;
    side_nxt.codes[0] = x33 > z33;
    side_nxt.codes[1] = x33 < -z33;
    side_nxt.codes[2] = y33 > z33;
    side_nxt.codes[3] = y33 < -z33;
    side_nxt.codes[4] = view.z[CoordW-1];
    side_nxt.pos      = !view.z[CoordW-1] && (view.z != '0);
    side_nxt.neg_x    = view.x[CoordW-1];
    side_nxt.neg_y    = view.y[CoordW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= view_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r <= side_nxt;
      numx_d_r <= {mulx[DivNumW-17:0], 16'd0};
      numy_d_r <= {muly[DivNumW-17:0], 16'd0};
      den_d_r  <= side_nxt.pos ? view.z[DivDenW-1:0] : DivDenW'(1);
    end
  end

  // quotient pipelines
  vvtcp_div_pipe #(.NW(DivNumW), .DW(DivDenW)) u_div_x (
    .clk (clk), .en (en), .num (numx_d_r), .den (den_d_r), .quo (qx)
  );
  vvtcp_div_pipe #(.NW(DivNumW), .DW(DivDenW)) u_div_y (
    .clk (clk), .en (en), .num (numy_d_r), .den (den_d_r), .quo (qy)
  );
  vvtcp_div_pipe #(.NW(DivNumW), .DW(DivDenW)) u_div_r (
    .clk (clk), .en (en), .num (RecipNum), .den (den_d_r), .quo (qr)
  );

  vvtcp_delay #(.W(SideW), .DEPTH(DivNumW)) u_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vd_r),
    .data_i  (side_d_r),
    .valid_o (ve),
    .data_o  (side_e)
  );

  // screen position and reciprocal depth
  always_comb begin
    sqx  = side_e.neg_x ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
    sqy  = side_e.neg_y ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
    sumx = signed'(SumW'({width_r, 16'd0})) + SumW'(sqx);
    sumy = signed'(SumW'({height_r, 16'd0})) - SumW'(sqy);
    sx_nxt = '0;
    sy_nxt = '0;
    rd_nxt = '0;
    if (side_e.pos) begin
      sx_nxt = sat_q(sumx[SumW-1:1]);
      sy_nxt = sat_q(sumy[SumW-1:1]);
      rd_nxt = (qr >= DivNumW'(OneQ16)) ? OneQ16 : qr[RecipW-1:0];
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r    <= side_e.view.x;
      vy_r    <= side_e.view.y;
      vz_r    <= side_e.view.z;
      codes_r <= side_e.codes;
      proj_r  <= side_e.pos;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      rd_r    <= rd_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_view_x      = vx_r;
  assign out_view_y      = vy_r;
  assign out_view_z      = vz_r;
  assign out_clip_codes  = codes_r;
  assign out_projected   = proj_r;
  assign out_screen_x    = sx_r;
  assign out_screen_y    = sy_r;
  assign out_recip_depth = rd_r;
endmodule

@@ hw/rtl/vvtcp_rotate.sv @@
module vvtcp_rotate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [vvtcp_pkg::CoordW-1:0] world_x,
  input  logic [vvtcp_pkg::CoordW-1:0] world_y,
  input  logic [vvtcp_pkg::CoordW-1:0] world_z,
  input  logic                        skip_translate,
  input  logic [vvtcp_pkg::CoordW-1:0] pos_x,
  input  logic [vvtcp_pkg::CoordW-1:0] pos_y,
  input  logic [vvtcp_pkg::CoordW-1:0] pos_z,
  input  logic [vvtcp_pkg::RowW-1:0]   row_r0,
  input  logic [vvtcp_pkg::RowW-1:0]   row_u0,
  input  logic [vvtcp_pkg::RowW-1:0]   row_f0,
  output logic                        view_valid,
  output vvtcp_pkg::view_t            view
);
  import vvtcp_pkg::*;

  localparam int unsigned TW   = CoordW + 1;
  localparam int unsigned PW   = TW + EntryW;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned HW   = SW - 14;

  logic                 va_r, vb_r, vc_r;
  logic signed [TW-1:0] t_r [3];
  logic signed [PW-1:0] prod_r [3][3];
  view_t                view_r;
  logic [RowW-1:0]      rows [3];
  logic signed [TW-1:0] t_nxt [3];
  logic signed [SW-1:0] sum [3];
  logic [HW-1:0]        sh [3];
  logic [CoordW-1:0]    sat [3];

  assign rows[0] = row_r0;
  assign rows[1] = row_u0;
  assign rows[2] = row_f0;

  function automatic logic [CoordW-1:0] sat_h(input logic [HW-1:0] v);
    if (v[HW-1:CoordW-1] == '0 || v[HW-1:CoordW-1] == '1) begin
      sat_h = v[CoordW-1:0];
    end else if (v[HW-1]) begin
      sat_h = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat_h = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  // translate by camera position unless skipped
  always_comb begin
    t_nxt[0] = signed'({world_x[CoordW-1], world_x});
    t_nxt[1] = signed'({world_y[CoordW-1], world_y});
    t_nxt[2] = signed'({world_z[CoordW-1], world_z});
    if (!skip_translate) begin
      t_nxt[0] = t_nxt[0] - signed'({pos_x[CoordW-1], pos_x});
      t_nxt[1] = t_nxt[1] - signed'({pos_y[CoordW-1], pos_y});
      t_nxt[2] = t_nxt[2] - signed'({pos_z[CoordW-1], pos_z});
    end
  end

  // row sums, floor shift by 14, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2]);
      sh[r]  = sum[r][SW-1:14];
      sat[r] = sat_h(sh[r]);
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // data stages: translate, multiply, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        t_r[c] <= t_nxt[c];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= t_r[c] * row_entry(rows[r], c);
        end
      end
      view_r.x <= sat[0];
      view_r.y <= sat[1];
      view_r.z <= sat[2];
    end
  end

  assign view_valid = vc_r;
  assign view       = view_r;
endmodule

@@ hw/rtl/vvtcp_div_pipe.sv @@
module vvtcp_div_pipe #(
  parameter int unsigned NW = vvtcp_pkg::DivNumW,
  parameter int unsigned DW = vvtcp_pkg::DivDenW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  // one quotient bit per stage, restoring
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [NW-1:0] num_p;
    logic [NW-1:0] quo_p;
    logic [DW-1:0] den_p;
    logic [DW:0]   cat;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num;
      assign quo_p = '0;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_r[s-1];
      assign num_p = num_r[s-1];
      assign quo_p = quo_r[s-1];
      assign den_p = den_r[s-1];
    end

    assign cat  = {rem_p, num_p[NW-1]};
    assign ge   = cat >= {1'b0, den_p};
    assign diff = cat - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DW-1:0] : cat[DW-1:0];
        num_r[s] <= {num_p[NW-2:0], 1'b0};
        quo_r[s] <= {quo_p[NW-2:0], ge};
        den_r[s] <= den_p;
      end
    end
  end

  assign quo = quo_r[NW-1];
endmodule

@@ hw/rtl/vvtcp_delay.sv @@
module vvtcp_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = vvtcp_pkg::DivNumW
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  logic [DEPTH-1:0] v_r;
  logic [W-1:0]     d_r [DEPTH];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], valid_i};
    end
  end

  // payload taps
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        d_r[i] <= d_r[i-1];
      end
    end
  end

  assign valid_o = v_r[DEPTH-1];
  assign data_o  = d_r[DEPTH-1];
endmodule
